FILE: hw/rtl/bbf_pkg.sv
// ============================================================================
// bbf_pkg
// Shared types and constants of the bilinear bitmap band filter.
// ============================================================================
package bbf_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_RECT_MIN_X = 3'd0;
    localparam logic [2:0] CFG_RECT_MAX_X = 3'd1;
    localparam logic [2:0] CFG_RECT_MIN_Y = 3'd2;
    localparam logic [2:0] CFG_RECT_MAX_Y = 3'd3;
    localparam logic [2:0] CFG_BAND_LOW   = 3'd4;
    localparam logic [2:0] CFG_BAND_HIGH  = 3'd5;
    localparam logic [2:0] CFG_FEATHER    = 3'd6;

    // floor(v / 255) as (v * RECIP_255) >> RECIP_SH, at most one too high
    localparam logic [15:0] RECIP_255 = 16'd32897;
    localparam int          RECIP_SH  = 23;
    localparam logic [7:0]  PIX_MAX   = 8'hFF;

    typedef logic [15:0] t_addr;
    typedef logic [7:0]  t_pix;

    typedef struct packed {
        logic  vld;
        logic  op;
        t_addr waddr;
        t_pix  wdata;
    } t_tag;

    typedef struct packed {
        logic vld;
        logic op;
    } t_ctl;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic [16:0]        band_low;
        logic [16:0]        band_high;
        logic [16:0]        feather;
    } t_cfg;

endpackage

FILE: hw/rtl/bilinear_bitmap_band_filter_unit.sv
// ============================================================================
// bilinear_bitmap_band_filter_unit
// Bitmap store with bilinear sampling and a feathered band filter.
// ============================================================================
// One request enters per clock while no result waits at the output. A
// sample passes the mapping, the one-bit-per-stage coordinate divider
// (clog2 + 16 stages), the store, the blend and the 16-stage feather
// divider in that order; pixel writes give no result and reach the store
// at the same depth as sample reads, so samples see every earlier write. The whole
// pipeline holds while a result waits at the output. Unwritten pixels read
// as unknown; write every pixel a sample can touch first.
// ============================================================================
module bilinear_bitmap_band_filter_unit #(
    parameter int IMG_W = 256,
    parameter int IMG_H = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0]        i_pixel_address,
    input  logic [7:0]         i_pixel_value,

    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_filtered_value,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int LB = $clog2((IMG_W > IMG_H) ? IMG_W : IMG_H);
    localparam int QW = LB + 16;

    bbf_pkg::t_cfg r_cfg;
    bbf_pkg::t_tag in_tag;
    bbf_pkg::t_tag map_tag;
    bbf_pkg::t_ctl fetch_ctl, interp_ctl;
    logic [QW-1:0] tx, ty;
    logic [3:0][7:0] pix;
    logic [15:0]   fx, fy, m;
    logic          en;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x     <= 32'sd0;
            r_cfg.max_x     <= 32'sd65536;
            r_cfg.min_y     <= 32'sd0;
            r_cfg.max_y     <= 32'sd65536;
            r_cfg.band_low  <= 17'd0;
            r_cfg.band_high <= 17'd65536;
            r_cfg.feather   <= 17'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bbf_pkg::CFG_RECT_MIN_X: r_cfg.min_x     <= i_cfg_data;
                bbf_pkg::CFG_RECT_MAX_X: r_cfg.max_x     <= i_cfg_data;
                bbf_pkg::CFG_RECT_MIN_Y: r_cfg.min_y     <= i_cfg_data;
                bbf_pkg::CFG_RECT_MAX_Y: r_cfg.max_y     <= i_cfg_data;
                bbf_pkg::CFG_BAND_LOW:   r_cfg.band_low  <= i_cfg_data[16:0];
                bbf_pkg::CFG_BAND_HIGH:  r_cfg.band_high <= i_cfg_data[16:0];
                bbf_pkg::CFG_FEATHER:    r_cfg.feather   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign in_tag.vld   = i_valid;
    assign in_tag.op    = i_opcode;
    assign in_tag.waddr = i_pixel_address;
    assign in_tag.wdata = i_pixel_value;

    bbf_map #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (in_tag),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_cfg   (r_cfg),
        .o_tag   (map_tag),
        .o_tx    (tx),
        .o_ty    (ty)
    );

    bbf_fetch #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (map_tag),
        .i_tx    (tx),
        .i_ty    (ty),
        .o_ctl   (fetch_ctl),
        .o_pix   (pix),
        .o_fx    (fx),
        .o_fy    (fy)
    );

    bbf_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (fetch_ctl),
        .i_pix   (pix),
        .i_fx    (fx),
        .i_fy    (fy),
        .o_ctl   (interp_ctl),
        .o_m     (m)
    );

    bbf_band u_band (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_ctl       (interp_ctl),
        .i_m         (m),
        .i_band_low  (r_cfg.band_low),
        .i_band_high (r_cfg.band_high),
        .i_feather   (r_cfg.feather),
        .o_valid     (o_valid),
        .o_value     (o_filtered_value)
    );

endmodule

FILE: hw/rtl/bbf_map.sv
// ============================================================================
// bbf_map
// World to bitmap coordinate mapping: offset, scale, bit-per-stage divide
// and clamp, both axes in parallel lanes.
// ============================================================================
module bbf_map #(
    parameter int IMG_W = 256,
    parameter int IMG_H = 256,
    localparam int LB = $clog2((IMG_W > IMG_H) ? IMG_W : IMG_H),
    localparam int QW = LB + 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  bbf_pkg::t_tag      i_tag,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  bbf_pkg::t_cfg      i_cfg,
    output bbf_pkg::t_tag      o_tag,
    output logic [QW-1:0]      o_tx,
    output logic [QW-1:0]      o_ty
);

    localparam int PW = 33 + LB;
    localparam logic [LB:0]   IMG_XV = (LB + 1)'(IMG_W);
    localparam logic [LB:0]   IMG_YV = (LB + 1)'(IMG_H);
    localparam logic [QW-1:0] TOP_X  = QW'(IMG_W - 1) << 16;
    localparam logic [QW-1:0] TOP_Y  = QW'(IMG_H - 1) << 16;

    bbf_pkg::t_tag r0_tag;
    logic [31:0]   r0_n [2];
    logic [31:0]   r0_d [2];
    logic          r0_z [2];

    bbf_pkg::t_tag r1_tag;
    logic [PW-1:0] r1_prod [2];
    logic [31:0]   r1_d [2];
    logic          r1_z [2];

    bbf_pkg::t_tag r_tg  [QW];
    logic [31:0]   r_rem [QW][2];
    logic [QW-1:0] r_low [QW][2];
    logic [QW-1:0] r_q   [QW][2];
    logic          r_sat [QW][2];
    logic          r_z   [QW][2];
    logic [31:0]   r_d   [QW][2];

    logic [31:0]   n_rem [QW][2];
    logic [QW-1:0] n_low [QW][2];
    logic [QW-1:0] n_q   [QW][2];
    logic          n_sat [QW][2];
    logic          n_z   [QW][2];
    logic [31:0]   n_d   [QW][2];

    logic [32:0]   n0_nx, n0_ny, n0_dx, n0_dy;
    logic [QW-1:0] n_tx, n_ty;
    logic [QW-1:0] r_tx, r_ty;
    bbf_pkg::t_tag r_otag;

    assign n0_nx = {i_pos_x[31], i_pos_x} - {i_cfg.min_x[31], i_cfg.min_x};
    assign n0_ny = {i_pos_y[31], i_pos_y} - {i_cfg.min_y[31], i_cfg.min_y};
    assign n0_dx = {i_cfg.max_x[31], i_cfg.max_x} - {i_cfg.min_x[31], i_cfg.min_x};
    assign n0_dy = {i_cfg.max_y[31], i_cfg.max_y} - {i_cfg.min_y[31], i_cfg.min_y};

    always_comb begin
        logic [31:0]   rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic          sat_in;
        logic [32:0]   t;
        logic [32:0]   s;
        for (int j = 0; j < QW; j++) begin
            for (int a = 0; a < 2; a++) begin
                if (j == 0) begin
                    rem_in = r1_prod[a][LB+31:LB];
                    low_in = {r1_prod[a][LB-1:0], 16'h0000};
                    q_in   = '0;
                    sat_in = (r1_prod[a][PW-1:LB] >= {1'b0, r1_d[a]});
                    n_z[j][a] = r1_z[a];
                    n_d[j][a] = r1_d[a];
                end else begin
                    rem_in = r_rem[j-1][a];
                    low_in = r_low[j-1][a];
                    q_in   = r_q[j-1][a];
                    sat_in = r_sat[j-1][a];
                    n_z[j][a] = r_z[j-1][a];
                    n_d[j][a] = r_d[j-1][a];
                end
                t = {rem_in, low_in[QW-1]};
                s = t - {1'b0, n_d[j][a]};
                if (t >= {1'b0, n_d[j][a]}) begin
                    n_rem[j][a] = s[31:0];
                    n_q[j][a]   = {q_in[QW-2:0], 1'b1};
                end else begin
                    n_rem[j][a] = t[31:0];
                    n_q[j][a]   = {q_in[QW-2:0], 1'b0};
                end
                n_low[j][a] = {low_in[QW-2:0], 1'b0};
                n_sat[j][a] = sat_in;
            end
        end
    end

    always_comb begin
        if (r_z[QW-1][0]) begin
            n_tx = '0;
        end else if (r_sat[QW-1][0] || (r_q[QW-1][0] > TOP_X)) begin
            n_tx = TOP_X;
        end else begin
            n_tx = r_q[QW-1][0];
        end
        if (r_z[QW-1][1]) begin
            n_ty = '0;
        end else if (r_sat[QW-1][1] || (r_q[QW-1][1] > TOP_Y)) begin
            n_ty = TOP_Y;
        end else begin
            n_ty = r_q[QW-1][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_tag.vld <= 1'b0;
            r1_tag.vld <= 1'b0;
            for (int j = 0; j < QW; j++) begin
                r_tg[j].vld <= 1'b0;
            end
            r_otag.vld <= 1'b0;
        end else if (i_en) begin
            r0_tag  <= i_tag;
            r0_n[0] <= n0_nx[31:0];
            r0_n[1] <= n0_ny[31:0];
            r0_d[0] <= n0_dx[31:0];
            r0_d[1] <= n0_dy[31:0];
            r0_z[0] <= n0_nx[32] || n0_dx[32] || (n0_dx == '0);
            r0_z[1] <= n0_ny[32] || n0_dy[32] || (n0_dy == '0);

            r1_tag     <= r0_tag;
            r1_prod[0] <= PW'(r0_n[0]) * PW'(IMG_XV);
            r1_prod[1] <= PW'(r0_n[1]) * PW'(IMG_YV);
            r1_d       <= r0_d;
            r1_z       <= r0_z;

            for (int j = 0; j < QW; j++) begin
                r_tg[j] <= (j == 0) ? r1_tag : r_tg[j-1];
                for (int a = 0; a < 2; a++) begin
                    r_rem[j][a] <= n_rem[j][a];
                    r_low[j][a] <= n_low[j][a];
                    r_q[j][a]   <= n_q[j][a];
                    r_sat[j][a] <= n_sat[j][a];
                    r_z[j][a]   <= n_z[j][a];
                    r_d[j][a]   <= n_d[j][a];
                end
            end

            r_otag <= r_tg[QW-1];
            r_tx   <= n_tx;
            r_ty   <= n_ty;
        end
    end

    assign o_tag = r_otag;
    assign o_tx  = r_tx;
    assign o_ty  = r_ty;

endmodule

FILE: hw/rtl/bbf_fetch.sv
// ============================================================================
// bbf_fetch
// Neighbor address generation and bitmap store, one bank per neighbor, all
// banks written by every pixel write request.
// ============================================================================
module bbf_fetch #(
    parameter int IMG_W = 256,
    parameter int IMG_H = 256,
    localparam int LB = $clog2((IMG_W > IMG_H) ? IMG_W : IMG_H),
    localparam int QW = LB + 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bbf_pkg::t_tag       i_tag,
    input  logic [QW-1:0]       i_tx,
    input  logic [QW-1:0]       i_ty,
    output bbf_pkg::t_ctl       o_ctl,
    output logic [3:0][7:0]     o_pix,
    output logic [15:0]         o_fx,
    output logic [15:0]         o_fy
);

    localparam logic [LB-1:0] XMAX = LB'(IMG_W - 1);
    localparam logic [LB-1:0] YMAX = LB'(IMG_H - 1);

    logic [LB-1:0] ix, iy, ix1, iy1, row0, row1;
    bbf_pkg::t_addr n_addr [4];

    bbf_pkg::t_tag  r_a_tag;
    bbf_pkg::t_addr r_addr [4];
    logic [15:0]    r_a_fx, r_a_fy;

    bbf_pkg::t_ctl  r_b_ctl;
    logic [3:0][7:0] r_pix;
    logic [15:0]    r_b_fx, r_b_fy;

    assign ix   = i_tx[QW-1:16];
    assign iy   = i_ty[QW-1:16];
    assign ix1  = (ix == XMAX) ? ix : ix + 1'b1;
    assign iy1  = (iy == YMAX) ? iy : iy + 1'b1;
    assign row0 = YMAX - iy;
    assign row1 = YMAX - iy1;

    assign n_addr[0] = bbf_pkg::t_addr'(row0 * IMG_W + ix);
    assign n_addr[1] = bbf_pkg::t_addr'(row0 * IMG_W + ix1);
    assign n_addr[2] = bbf_pkg::t_addr'(row1 * IMG_W + ix);
    assign n_addr[3] = bbf_pkg::t_addr'(row1 * IMG_W + ix1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.vld <= 1'b0;
            r_b_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_a_tag <= i_tag;
            r_addr  <= n_addr;
            r_a_fx  <= i_tx[15:0];
            r_a_fy  <= i_ty[15:0];

            r_b_ctl.vld <= r_a_tag.vld;
            r_b_ctl.op  <= r_a_tag.op;
            r_b_fx      <= r_a_fx;
            r_b_fy      <= r_a_fy;
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        bbf_pkg::t_pix mem [65536];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_a_tag.vld && (r_a_tag.op == bbf_pkg::OP_WRITE)) begin
                    mem[r_a_tag.waddr] <= r_a_tag.wdata;
                end
                r_pix[b] <= mem[r_addr[b]];
            end
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_pix = r_pix;
    assign o_fx  = r_b_fx;
    assign o_fy  = r_b_fy;

endmodule

FILE: hw/rtl/bbf_interp.sv
// ============================================================================
// bbf_interp
// Bilinear blend of the four neighbors, scale by 1/255 and saturate just
// below one.
// ============================================================================
module bbf_interp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  bbf_pkg::t_ctl   i_ctl,
    input  logic [3:0][7:0] i_pix,
    input  logic [15:0]     i_fx,
    input  logic [15:0]     i_fy,
    output bbf_pkg::t_ctl   o_ctl,
    output logic [15:0]     o_m
);

    bbf_pkg::t_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    logic [23:0]   r1_a0, r1_a1;
    logic [15:0]   r1_fy;
    logic [39:0]   r2_acc;
    logic [23:0]   r3_v;
    logic [16:0]   r3_qe;
    logic [15:0]   r4_m;

    logic [16:0] wx0, wy0;
    logic [23:0] n_a0, n_a1, v;
    logic [39:0] n_acc, prod;
    logic [24:0] chk;
    logic [16:0] q;

    assign wx0  = 17'h10000 - {1'b0, i_fx};
    assign n_a0 = 24'(25'(wx0) * 25'(i_pix[0]) + 25'(i_fx) * 25'(i_pix[1]));
    assign n_a1 = 24'(25'(wx0) * 25'(i_pix[2]) + 25'(i_fx) * 25'(i_pix[3]));

    assign wy0   = 17'h10000 - {1'b0, r1_fy};
    assign n_acc = 40'(wy0) * 40'(r1_a0) + 40'(r1_fy) * 40'(r1_a1);

    assign v    = r2_acc[39:16];
    assign prod = 40'(v) * 40'(bbf_pkg::RECIP_255);

    assign chk = 25'(r3_qe) * 25'(bbf_pkg::PIX_MAX);
    assign q   = (25'(r3_v) < chk) ? r3_qe - 1'b1 : r3_qe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.vld <= 1'b0;
            r2_ctl.vld <= 1'b0;
            r3_ctl.vld <= 1'b0;
            r4_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r1_a0  <= n_a0;
            r1_a1  <= n_a1;
            r1_fy  <= i_fy;

            r2_ctl <= r1_ctl;
            r2_acc <= n_acc;

            r3_ctl <= r2_ctl;
            r3_v   <= v;
            r3_qe  <= prod[39:bbf_pkg::RECIP_SH];

            r4_ctl <= r3_ctl;
            r4_m   <= q[16] ? 16'hFFFF : q[15:0];
        end
    end

    assign o_ctl = r4_ctl;
    assign o_m   = r4_m;

endmodule

FILE: hw/rtl/bbf_band.sv
// ============================================================================
// bbf_band
// Feathered band filter: zone select, ramp product, bit-per-stage divide by
// the feather half-width, output register.
// ============================================================================
module bbf_band (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  bbf_pkg::t_ctl i_ctl,
    input  logic [15:0]   i_m,
    input  logic [16:0]   i_band_low,
    input  logic [16:0]   i_band_high,
    input  logic [16:0]   i_feather,
    output logic          o_valid,
    output logic [15:0]   o_value
);

    localparam int DW = 16;

    typedef enum logic [1:0] {SEL_ZERO, SEL_PASS, SEL_RAMP} t_sel;

    logic [16:0]   r_h;
    logic [16:0]   dd;
    logic [33:0]   hp;

    logic [16:0]   m17;
    logic          inb, lower, upper;
    t_sel          n_sel;
    logic [16:0]   n_dist;

    bbf_pkg::t_ctl r1_ctl, r2_ctl;
    t_sel          r1_sel, r2_sel;
    logic [16:0]   r1_dist;
    logic [15:0]   r1_m, r2_m;
    logic [16:0]   r1_h, r2_h;
    logic [32:0]   r2_num;

    bbf_pkg::t_ctl r_ctl [DW];
    t_sel          r_sel [DW];
    logic [15:0]   r_m   [DW];
    logic [16:0]   r_hd  [DW];
    logic [16:0]   r_rem [DW];
    logic [15:0]   r_low [DW];
    logic [15:0]   r_q   [DW];

    logic [16:0]   n_rem [DW];
    logic [15:0]   n_low [DW];
    logic [15:0]   n_q   [DW];

    logic          r_out_valid;
    logic [15:0]   r_out_value;
    logic [15:0]   n_value;

    assign dd = (i_band_high > i_band_low) ? i_band_high - i_band_low : '0;
    assign hp = 34'(dd) * 34'(i_feather);

    always_ff @(posedge i_clk) begin
        r_h <= hp[33:17];
    end

    assign m17   = {1'b0, i_m};
    assign inb   = (m17 > i_band_low) && (m17 < i_band_high);
    assign lower = 18'(m17) < (18'(i_band_low) + 18'(r_h));
    assign upper = (18'(m17) + 18'(r_h)) > 18'(i_band_high);

    always_comb begin
        n_dist = '0;
        priority if (!inb) begin
            n_sel = SEL_ZERO;
        end else if (r_h == '0) begin
            n_sel = SEL_PASS;
        end else if (lower) begin
            n_sel  = SEL_RAMP;
            n_dist = m17 - i_band_low;
        end else if (upper) begin
            n_sel  = SEL_RAMP;
            n_dist = i_band_high - m17;
        end else begin
            n_sel = SEL_PASS;
        end
    end

    always_comb begin
        logic [16:0] rem_in;
        logic [15:0] low_in;
        logic [15:0] q_in;
        logic [16:0] hd;
        logic [17:0] t;
        logic [17:0] s;
        for (int j = 0; j < DW; j++) begin
            if (j == 0) begin
                rem_in = r2_num[32:16];
                low_in = r2_num[15:0];
                q_in   = '0;
                hd     = r2_h;
            end else begin
                rem_in = r_rem[j-1];
                low_in = r_low[j-1];
                q_in   = r_q[j-1];
                hd     = r_hd[j-1];
            end
            t = {rem_in, low_in[15]};
            s = t - {1'b0, hd};
            if (t >= {1'b0, hd}) begin
                n_rem[j] = s[16:0];
                n_q[j]   = {q_in[14:0], 1'b1};
            end else begin
                n_rem[j] = t[16:0];
                n_q[j]   = {q_in[14:0], 1'b0};
            end
            n_low[j] = {low_in[14:0], 1'b0};
        end
    end

    always_comb begin
        unique case (r_sel[DW-1])
            SEL_ZERO: n_value = '0;
            SEL_PASS: n_value = r_m[DW-1];
            SEL_RAMP: n_value = r_q[DW-1];
            default:  n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.vld <= 1'b0;
            r2_ctl.vld <= 1'b0;
            for (int j = 0; j < DW; j++) begin
                r_ctl[j].vld <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl  <= i_ctl;
            r1_sel  <= n_sel;
            r1_dist <= n_dist;
            r1_m    <= i_m;
            r1_h    <= r_h;

            r2_ctl <= r1_ctl;
            r2_sel <= r1_sel;
            r2_m   <= r1_m;
            r2_h   <= r1_h;
            r2_num <= 33'(r1_m) * 33'(r1_dist);

            for (int j = 0; j < DW; j++) begin
                r_ctl[j] <= (j == 0) ? r2_ctl : r_ctl[j-1];
                r_sel[j] <= (j == 0) ? r2_sel : r_sel[j-1];
                r_m[j]   <= (j == 0) ? r2_m   : r_m[j-1];
                r_hd[j]  <= (j == 0) ? r2_h   : r_hd[j-1];
                r_rem[j] <= n_rem[j];
                r_low[j] <= n_low[j];
                r_q[j]   <= n_q[j];
            end

            r_out_valid <= r_ctl[DW-1].vld && (r_ctl[DW-1].op == bbf_pkg::OP_SAMPLE);
            r_out_value <= n_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

endmodule

FILE: hw/rtl/bbf_chk.sv
// ============================================================================
// bbf_chk
// Port-level checks of the filter unit handshake, reset and stall behavior.
// ============================================================================
module bbf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_filtered_value,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filtered_value))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("request ready does not follow output stall");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> o_cfg_ready)
        else $error("config port not ready");

endmodule

bind bilinear_bitmap_band_filter_unit bbf_chk u_chk (.*);
